@@ src/integer_to_radix_ascii_unit_assert.svh @@
`ifndef INTEGER_TO_RADIX_ASCII_UNIT_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_UNIT_ASSERT_SVH

// same-cycle implication
`define ITRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("itra: same-cycle check failed");

// next-cycle implication
`define ITRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("itra: next-cycle check failed");

`endif

@@ src/itra_pkg.sv @@
package itra_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_RADIX_DEF   = 36;

  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [CHAR_W-1:0]  CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0]  CH_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0]  CH_UPA   = 7'h41;
  localparam logic [CHAR_W-1:0]  CH_UPZ   = 7'h5A;
  localparam logic [CHAR_W-1:0]  CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0]  CH_NONE  = 7'h00;
  localparam logic [DIGIT_W-1:0] DEC_BASE = 6'd10;

  typedef struct packed {
    logic invalid;
    logic neg;
  } flags_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              empty_res;
  } res_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < DEC_BASE) begin
      digit_char = CH_ZERO + dx;
    end else begin
      digit_char = CH_UPA + dx - {1'b0, DEC_BASE};
    end
  endfunction

endpackage

@@ src/itra_div.sv @@
module itra_div #(
  parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [VALUE_WIDTH-1:0]         dividend_i,
  input  logic [itra_pkg::RADIX_W-1:0]   divisor_i,
  output logic                           done_o,
  output logic [VALUE_WIDTH-1:0]         quotient_o,
  output logic [itra_pkg::DIGIT_W-1:0]   remainder_o
);

  localparam int BW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int RW = itra_pkg::RADIX_W;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [BW-1:0]     bit_q, bit_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [RW:0]       shifted;
  logic              ge;

  assign shifted = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign ge      = shifted >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    bit_d  = bit_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      bit_d  = BW'(VALUE_WIDTH - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? RW'(shifted - {1'b0, divisor_i}) : RW'(shifted);
      quo_d = {quo_q[VALUE_WIDTH-2:0], ge};
      bit_d = bit_q - BW'(1);
      if (bit_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

@@ src/itra_front.sv @@
module itra_front #(
  parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_RADIX   = itra_pkg::MAX_RADIX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic [7:0]                    radix_i,
  output logic                          cmd_valid_o,
  output itra_pkg::flags_t              cmd_flags_o,
  output logic [VALUE_WIDTH-1:0]        cmd_mag_o,
  output logic [itra_pkg::RADIX_W-1:0]  cmd_radix_o,
  input  logic                          cmd_take_i
);

  localparam int RW = itra_pkg::RADIX_W;

  itra_pkg::flags_t       flags_in;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic                   accept;

  itra_pkg::flags_t       q_flg [2];
  logic [VALUE_WIDTH-1:0] q_mag [2];
  logic [RW-1:0]          q_rad [2];
  logic                   wr_ptr_q, rd_ptr_q;
  logic [1:0]             cnt_q, cnt_d;

  always_comb begin
    flags_in.invalid = (radix_i < 8'd2) || (radix_i > 8'(MAX_RADIX));
    flags_in.neg     = value_i[VALUE_WIDTH-1];
    mag_in = flags_in.neg ? (~value_i + VALUE_WIDTH'(1)) : value_i;
  end

  assign full   = cnt_q == 2'd2;
  assign accept = push && !full;

  always_comb begin
    cnt_d = cnt_q;
    if (accept && !cmd_take_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!accept && cmd_take_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (cmd_take_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_flg[wr_ptr_q] <= flags_in;
      q_mag[wr_ptr_q] <= mag_in;
      q_rad[wr_ptr_q] <= radix_i[RW-1:0];
    end
  end

  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_flags_o = q_flg[rd_ptr_q];
  assign cmd_mag_o   = q_mag[rd_ptr_q];
  assign cmd_radix_o = q_rad[rd_ptr_q];

endmodule

@@ src/itra_back.sv @@
module itra_back #(
  parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  input  itra_pkg::flags_t                  cmd_flags_i,
  input  logic [VALUE_WIDTH-1:0]            cmd_mag_i,
  input  logic [itra_pkg::RADIX_W-1:0]      cmd_radix_i,
  output logic                              cmd_take_o,
  output logic                              empty,
  input  logic                              pop,
  output logic [itra_pkg::CHAR_W-1:0]       character_o,
  output logic                              last_o,
  output logic                              empty_res_o
);

  localparam int SW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int CW = $clog2(VALUE_WIDTH + 1);
  localparam int RW = itra_pkg::RADIX_W;
  localparam int DW = itra_pkg::DIGIT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INV  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          neg_q, neg_d;
  logic [RW-1:0] rad_q, rad_d;

  logic                   div_start, div_done;
  logic [VALUE_WIDTH-1:0] div_dividend, div_quo;
  logic [DW-1:0]          div_rem;

  logic [DW-1:0] store [VALUE_WIDTH];
  logic [DW-1:0] rd_data_q;
  logic          st_we;
  logic [CW-1:0] cnt_m1;

  itra_pkg::res_t o_buf [2];
  itra_pkg::res_t res_in;
  logic           o_wr_q, o_rd_q;
  logic [1:0]     o_cnt_q, o_cnt_d;
  logic           o_push, o_pop, o_space;

  itra_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (rad_d),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign div_dividend = (state_q == S_IDLE) ? cmd_mag_i : div_quo;
  assign cnt_m1       = cnt_q - CW'(1);
  assign o_space      = o_cnt_q != 2'd2;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    neg_d      = neg_q;
    rad_d      = rad_q;
    cmd_take_o = 1'b0;
    div_start  = 1'b0;
    st_we      = 1'b0;
    o_push     = 1'b0;
    res_in.character = itra_pkg::CH_NONE;
    res_in.last      = 1'b0;
    res_in.empty_res = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          if (cmd_flags_i.invalid) begin
            state_d = S_INV;
          end else begin
            neg_d     = cmd_flags_i.neg;
            rad_d     = cmd_radix_i;
            cnt_d     = '0;
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_INV: begin
        res_in.last      = 1'b1;
        res_in.empty_res = 1'b1;
        if (o_space) begin
          o_push  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          st_we = 1'b1;
          cnt_d = cnt_q + CW'(1);
          if (div_quo != '0) begin
            div_start = 1'b1;
          end else begin
            state_d = neg_q ? S_SIGN : S_RD;
          end
        end
      end
      S_SIGN: begin
        res_in.character = itra_pkg::CH_MINUS;
        if (o_space) begin
          o_push  = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        res_in.character = itra_pkg::digit_char(rd_data_q);
        res_in.last      = cnt_q == CW'(1);
        if (o_space) begin
          o_push  = 1'b1;
          cnt_d   = cnt_m1;
          state_d = (cnt_q == CW'(1)) ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      neg_q   <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
  end

  // digit store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store[cnt_q[SW-1:0]] <= div_rem;
    end
    rd_data_q <= store[cnt_m1[SW-1:0]];
  end

  // result queue
  assign o_pop = pop && !empty;

  always_comb begin
    o_cnt_d = o_cnt_q;
    if (o_push && !o_pop) begin
      o_cnt_d = o_cnt_q + 2'd1;
    end else if (!o_push && o_pop) begin
      o_cnt_d = o_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_wr_q  <= 1'b0;
      o_rd_q  <= 1'b0;
      o_cnt_q <= '0;
    end else begin
      o_cnt_q <= o_cnt_d;
      if (o_push) begin
        o_wr_q <= ~o_wr_q;
      end
      if (o_pop) begin
        o_rd_q <= ~o_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_push) begin
      o_buf[o_wr_q] <= res_in;
    end
  end

  assign empty       = o_cnt_q == 2'd0;
  assign character_o = o_buf[o_rd_q].character;
  assign last_o      = o_buf[o_rd_q].last;
  assign empty_res_o = o_buf[o_rd_q].empty_res;

endmodule

@@ src/integer_to_radix_ascii_unit.sv @@
// channel   direction  handshake              words
// ------    ---------  ---------------------  -------------------------------------
// input     in         push / full            value_i, radix_i
// result    out        empty / pop            character_o, last_o, empty_res_o
//
// Each digit comes from the bit-serial restoring divider and goes into the digit
// store; the digits are then read back most significant first (S_RD, then S_EMIT),
// after a sign character for a negative value. An invalid base gives one empty result
// word. A 2-deep input queue and a 2-deep result queue decouple the ports; pop stalls
// hold the output phase, then fill both queues.
// Reset is asynchronous and clears all control state; the digit store is not cleared.
module integer_to_radix_ascii_unit #(
  parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_RADIX   = itra_pkg::MAX_RADIX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic [7:0]                    radix_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [itra_pkg::CHAR_W-1:0]   character_o,
  output logic                          last_o,
  output logic                          empty_res_o
);

  logic                                cmd_valid, cmd_take;
  itra_pkg::flags_t                    cmd_flags;
  logic [VALUE_WIDTH-1:0]              cmd_mag;
  logic [itra_pkg::RADIX_W-1:0]        cmd_radix;

  itra_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_RADIX   (MAX_RADIX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .value_i     (value_i),
    .radix_i     (radix_i),
    .cmd_valid_o (cmd_valid),
    .cmd_flags_o (cmd_flags),
    .cmd_mag_o   (cmd_mag),
    .cmd_radix_o (cmd_radix),
    .cmd_take_i  (cmd_take)
  );

  itra_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_flags_i (cmd_flags),
    .cmd_mag_i   (cmd_mag),
    .cmd_radix_i (cmd_radix),
    .cmd_take_o  (cmd_take),
    .empty       (empty),
    .pop         (pop),
    .character_o (character_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o)
  );

endmodule

@@ src/itra_checker.sv @@
`include "integer_to_radix_ascii_unit_assert.svh"

module itra_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        empty,
  input logic                        pop,
  input logic [itra_pkg::CHAR_W-1:0] character_o,
  input logic                        last_o,
  input logic                        empty_res_o
);

  logic shown;
  logic is_text;

  assign shown   = !empty;
  assign is_text = (character_o == itra_pkg::CH_MINUS) ||
                   ((character_o >= itra_pkg::CH_ZERO) && (character_o <= itra_pkg::CH_NINE)) ||
                   ((character_o >= itra_pkg::CH_UPA) && (character_o <= itra_pkg::CH_UPZ));

  `ITRA_ASSERT_NOW(a_empty_word, clk_i, rst_ni, shown && empty_res_o,
                   last_o && (character_o == itra_pkg::CH_NONE))
  `ITRA_ASSERT_NOW(a_text_word, clk_i, rst_ni, shown && !empty_res_o, is_text)
  `ITRA_ASSERT_NOW(a_sign_not_last, clk_i, rst_ni,
                   shown && (character_o == itra_pkg::CH_MINUS), !last_o)
  `ITRA_ASSERT_NEXT(a_word_held, clk_i, rst_ni, shown && !pop,
                    !empty && $stable(character_o) && $stable(last_o))

endmodule

bind integer_to_radix_ascii_unit itra_checker u_itra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .character_o (character_o),
  .last_o      (last_o),
  .empty_res_o (empty_res_o)
);

@@ dv/integer_to_radix_ascii_unit_tb.sv @@
module integer_to_radix_ascii_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MIN_RADIX    = 2;
  localparam int RANDOM_WORDS = 258;
  localparam int HOLD_AT      = 60;
  localparam int DRAIN_AT     = 150;
  localparam int LONG_HOLD    = 1500;
  localparam int DRAIN_CYCLES = 200;
  localparam int QUIET_LIMIT  = 20000;
  localparam int MAX_REPORTS  = 10;

  class ascii_scoreboard;
    itra_pkg::res_t pending_chars[$];
    int   mismatches;
    int   words_noted;
    int   invalid_noted;
    int   chars_checked;

    function void complain(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("ERROR @%0t: %s", $realtime, msg);
      end
    endfunction

    function void note_word(logic [31:0] value, logic [7:0] radix);
      logic [31:0]    magnitude;
      logic [5:0]     digits[$];
      itra_pkg::res_t r;
      words_noted++;
      if (radix < MIN_RADIX || radix > itra_pkg::MAX_RADIX_DEF) begin
        invalid_noted++;
        r.character = itra_pkg::CH_NONE;
        r.last      = 1'b1;
        r.empty_res = 1'b1;
        pending_chars.push_back(r);
        return;
      end
      magnitude = value[31] ? -value : value;
      do begin
        digits.push_back(6'(magnitude % radix));
        magnitude = magnitude / radix;
      end while (magnitude != 0);
      r.empty_res = 1'b0;
      if (value[31]) begin
        r.character = itra_pkg::CH_MINUS;
        r.last      = 1'b0;
        pending_chars.push_back(r);
      end
      for (int i = digits.size() - 1; i >= 0; i--) begin
        r.character = (digits[i] < itra_pkg::DEC_BASE)
                      ? itra_pkg::CH_ZERO + 7'(digits[i])
                      : itra_pkg::CH_UPA + 7'(digits[i] - itra_pkg::DEC_BASE);
        r.last      = (i == 0);
        pending_chars.push_back(r);
      end
    endfunction

    function void check_word(itra_pkg::res_t got);
      itra_pkg::res_t want;
      chars_checked++;
      if (pending_chars.size() == 0) begin
        complain($sformatf("unexpected word char=%h last=%b empty=%b",
                           got.character, got.last, got.empty_res));
        return;
      end
      want = pending_chars.pop_front();
      if (got.character !== want.character || got.last !== want.last ||
          got.empty_res !== want.empty_res) begin
        complain($sformatf("exp char=%h last=%b empty=%b, got char=%h last=%b empty=%b",
                           want.character, want.last, want.empty_res,
                           got.character, got.last, got.empty_res));
      end
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        push;
  logic                        full;
  logic signed [31:0]          value_i;
  logic [7:0]                  radix_i;
  logic                        empty;
  logic                        pop;
  logic [itra_pkg::CHAR_W-1:0] character_o;
  logic                        last_o;
  logic                        empty_res_o;

  logic            hold_req = 1'b0;
  int              quiet_cycles = 0;
  ascii_scoreboard sb = new();

  integer_to_radix_ascii_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .value_i     (value_i),
    .radix_i     (radix_i),
    .empty       (empty),
    .pop         (pop),
    .character_o (character_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [31:0] v, input logic [7:0] r);
    push    <= 1'b1;
    value_i <= v;
    radix_i <= r;
    do @(posedge clk_i); while (full);
    sb.note_word(v, r);
  endtask

  task automatic idle(input int cycles);
    if (cycles > 0) begin
      push <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (sb.pending_chars.size() != 0);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 40);
      1: return -$urandom_range(1, 40);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                     : 32'h8000_0000 + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_radix();
    case ($urandom_range(0, 19))
      0: return 8'($urandom_range(0, MIN_RADIX - 1));
      1: return 8'($urandom_range(itra_pkg::MAX_RADIX_DEF + 1, 255));
      2: return $urandom_range(0, 1) ? 8'(MIN_RADIX) : 8'(itra_pkg::MAX_RADIX_DEF);
      default: return 8'($urandom_range(MIN_RADIX, itra_pkg::MAX_RADIX_DEF));
    endcase
  endfunction

  initial begin : receiver
    int             hold_left;
    int             mode_left;
    int             stall_pct;
    itra_pkg::res_t got;
    hold_left = 0;
    mode_left = 0;
    stall_pct = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        got.character = character_o;
        got.last      = last_o;
        got.empty_res = empty_res_o;
        sb.check_word(got);
      end
      if (hold_req && hold_left == 0) begin
        hold_left = LONG_HOLD;
        hold_req <= 1'b0;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(8, 80);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 30;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(1, 100) > stall_pct);
      end
    end
  end

  initial begin : stimulus
    int sent;
    int burst_left;
    rst_ni = 1'b0;
    push    <= 1'b0;
    value_i <= '0;
    radix_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(32'd0, 8'd10);
    send_word(32'd0, 8'd2);
    send_word(32'd1, 8'd10);
    send_word(-32'd1, 8'd10);
    send_word(32'h7FFF_FFFF, 8'd10);
    send_word(32'h8000_0000, 8'd10);
    send_word(32'h8000_0000, 8'd2);
    send_word(32'h7FFF_FFFF, 8'd2);
    send_word(-32'd1, 8'd2);
    send_word(32'd35, 8'd36);
    send_word(-32'd35, 8'd36);
    send_word(32'h7FFF_FFFF, 8'd36);
    send_word(32'h8000_0000, 8'd36);
    send_word(32'd255, 8'd16);
    send_word(-32'd1234567, 8'd16);
    send_word(32'd100, 8'd3);
    send_word(32'd511, 8'd8);
    send_word(32'd123456789, 8'd10);
    send_word(-32'd987654321, 8'd7);
    send_word(32'd12, 8'd0);
    send_word(32'd12, 8'd1);
    send_word(-32'd5, 8'd37);
    send_word(32'd7, 8'd255);
    send_word(32'h8000_0000, 8'd128);
    wait_drained();

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst_left = $urandom_range(1, 12);
      while (burst_left > 0 && sent < RANDOM_WORDS) begin
        // stall the result side while the input keeps offering
        if (sent == HOLD_AT) begin
          hold_req  <= 1'b1;
          burst_left = 10;
        end
        if (sent == DRAIN_AT) begin
          wait_drained();
        end
        send_word(pick_value(), pick_radix());
        sent++;
        burst_left--;
      end
      idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Converted %0d words (%0d with an invalid base) into %0d checked characters.",
             sb.words_noted, sb.invalid_noted, sb.chars_checked);
    $display("Covered value extremes, bases %0d to %0d, invalid bases, back-pressure and drains.",
             MIN_RADIX, itra_pkg::MAX_RADIX_DEF);
    if (sb.mismatches == 0 && sb.pending_chars.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d characters never seen",
               sb.mismatches, sb.pending_chars.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
